/* design/nrtd_pkg.sv */
// Shared types and constants for the nibble run-length character decoder.
// No dependencies; used by nrtd_nib_acc and nibble_rle_tile_decoder.
`timescale 1ns / 1ps

package nrtd_pkg;

	localparam int CHAR_W        = 12;
	localparam int NIB_W         = 4;
	localparam int NIBS_PER_WORD = 8;
	localparam int WORD_W        = NIB_W * NIBS_PER_WORD;
	localparam int ACC_W         = NIB_W * (NIBS_PER_WORD - 1);
	localparam int NCNT_W        = $clog2(NIBS_PER_WORD);
	localparam int IDX_W         = 13;
	localparam int BYTE_W        = 8;

	// Character count after reset.
	localparam logic [CHAR_W-1:0] CHAR_COUNT_RST = CHAR_W'(1);

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              start_new;
	} byte_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] pixel_word;
		logic [IDX_W-1:0]  word_index;
		logic              last_of_run;
		logic              final_word;
	} word_item_t;

	// Control from the sequencer to the nibble accumulator.
	typedef struct packed {
		logic             clear;
		logic             step;
		logic [NIB_W-1:0] value;
	} acc_ctrl_t;

endpackage

/* design/nrtd_nib_acc.sv */
// Nibble shift accumulator: shifts one nibble per step and flags a full word.
// Depends on nrtd_pkg.
`timescale 1ns / 1ps

module nrtd_nib_acc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nrtd_pkg::acc_ctrl_t          ctrl,
	output logic [nrtd_pkg::WORD_W-1:0]  word,
	output logic                         full
);

	localparam logic [nrtd_pkg::NCNT_W-1:0] LastCnt =
		nrtd_pkg::NCNT_W'(nrtd_pkg::NIBS_PER_WORD - 1);

	logic [nrtd_pkg::ACC_W-1:0]  acc_q;
	logic [nrtd_pkg::NCNT_W-1:0] cnt_q;

	// The step that brings in the eighth nibble completes the word.
	assign full = ctrl.step && (cnt_q == LastCnt);
	assign word = {acc_q, ctrl.value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (ctrl.step) begin
			if (cnt_q == LastCnt) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= {acc_q[nrtd_pkg::ACC_W-nrtd_pkg::NIB_W-1:0], ctrl.value};
				cnt_q <= cnt_q + nrtd_pkg::NCNT_W'(1);
			end
		end
	end

endmodule

/* design/nibble_rle_tile_decoder.sv */
// Top level of the nibble run-length character decoder: sequencer, word limit and output slots.
// Depends on nrtd_pkg and nrtd_nib_acc.
`timescale 1ns / 1ps

// Each input item is one run byte: the upper nibble plus one repeats the lower nibble into a
// shift accumulator, one nibble per clock through a single shared shift unit, so each byte adds
// 1 to 16 nibbles; its finished words (0 to 2) then go out one per clock while the output
// does not stall. The input is stalled while a byte is expanded and its words are delivered.
// Each group of eight nibbles forms a 32-bit word, first nibble in the top bits. Output stops
// after four words per character of cfg_data (clamped to MAX_CHARS); bytes after that are
// accepted and ignored until an item with start_new set. Write cfg_data only while the decoder
// is idle; cfg_ready is always high.
module nibble_rle_tile_decoder #(
	parameter int MAX_CHARS = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  nrtd_pkg::byte_item_t          byte_item,
	output logic                          word_valid,
	input  logic                          word_stall,
	output nrtd_pkg::word_item_t          word_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nrtd_pkg::CHAR_W-1:0]   cfg_data
);

	localparam int LimW = $clog2(MAX_CHARS * 4 + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [nrtd_pkg::CHAR_W-1:0]  char_count_q;
	logic [LimW-1:0]              words_q;
	logic                         limit_q;
	logic [nrtd_pkg::NIB_W-1:0]   value_q;
	logic [nrtd_pkg::NIB_W-1:0]   rem_q;
	logic [1:0]                   n_q;
	logic                         ptr_q;

	logic [nrtd_pkg::WORD_W-1:0]  slot_word_q  [2];
	logic [nrtd_pkg::IDX_W-1:0]   slot_idx_q   [2];
	logic                         slot_final_q [2];

	logic [nrtd_pkg::CHAR_W-1:0]  chars_eff;
	logic [LimW-1:0]              lim;
	logic [LimW-1:0]              words_inc;
	nrtd_pkg::acc_ctrl_t          acc_ctrl;
	logic [nrtd_pkg::WORD_W-1:0]  acc_word;
	logic                         acc_full;
	logic                         run_drop;
	logic                         run_emit;
	logic                         run_hit;
	logic                         run_end;
	logic [1:0]                   n_after;
	logic                         ptr_last;

	assign cfg_ready  = 1'b1;
	assign byte_stall = (state_q != ST_IDLE);
	assign word_valid = (state_q == ST_EMIT);

	assign chars_eff = (char_count_q > nrtd_pkg::CHAR_W'(MAX_CHARS)) ?
		nrtd_pkg::CHAR_W'(MAX_CHARS) : char_count_q;
	assign lim       = LimW'({chars_eff, 2'b00});
	assign words_inc = words_q + LimW'(1);

	always_comb begin
		acc_ctrl.clear = (state_q == ST_IDLE) && byte_valid && byte_item.start_new;
		acc_ctrl.step  = (state_q == ST_RUN);
		acc_ctrl.value = value_q;
	end

	nrtd_nib_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.word   (acc_word),
		.full   (acc_full)
	);

	// A word that completes with the limit already met is dropped; the word that meets the
	// limit is kept and ends the run, discarding the rest of the byte.
	assign run_drop = acc_full && (words_q >= lim);
	assign run_emit = acc_full && !run_drop;
	assign run_hit  = run_emit && (words_inc >= lim);
	assign run_end  = run_drop || run_hit || (rem_q == '0);
	assign n_after  = n_q + {1'b0, run_emit};
	assign ptr_last = ({1'b0, ptr_q} == (n_q - 2'd1));

	always_comb begin
		word_item.pixel_word  = slot_word_q[ptr_q];
		word_item.word_index  = slot_idx_q[ptr_q];
		word_item.last_of_run = ptr_last;
		word_item.final_word  = slot_final_q[ptr_q];
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RUN) && run_emit) begin
			slot_word_q[n_q[0]]  <= acc_word;
			slot_idx_q[n_q[0]]   <= nrtd_pkg::IDX_W'(words_q);
			slot_final_q[n_q[0]] <= (words_inc == lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			char_count_q <= nrtd_pkg::CHAR_COUNT_RST;
			words_q      <= '0;
			limit_q      <= 1'b0;
			value_q      <= '0;
			rem_q        <= '0;
			n_q          <= '0;
			ptr_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				char_count_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (byte_valid) begin
						if (byte_item.start_new) begin
							words_q <= '0;
							limit_q <= 1'b0;
						end
						value_q <= byte_item.packed_byte[nrtd_pkg::NIB_W-1:0];
						rem_q   <= byte_item.packed_byte[nrtd_pkg::BYTE_W-1:nrtd_pkg::NIB_W];
						n_q     <= '0;
						ptr_q   <= 1'b0;
						if (byte_item.start_new || !limit_q) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (run_drop || run_hit) begin
						limit_q <= 1'b1;
					end
					if (run_emit) begin
						words_q <= words_inc;
					end
					n_q   <= n_after;
					rem_q <= rem_q - nrtd_pkg::NIB_W'(1);
					if (run_end) begin
						state_q <= (n_after != '0) ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!word_stall) begin
						if (ptr_last) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// Delivering a word always means at least one slot was filled.
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (n_q != 2'd0))
		else $error("word presented with no filled slot");

	// A byte run never fills more than two slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		n_q != 2'd3)
		else $error("slot count overflow");

	// The word that meets the limit has already latched the limit flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_item.final_word) |-> limit_q)
		else $error("final word without limit flag");

	// A delivered last word returns the decoder to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && !word_stall && word_item.last_of_run) |=> !byte_stall)
		else $error("decoder did not return to idle after last word");
`endif

endmodule
